// ===== rtl/mfd_pkg.sv =====
// Shared types and constants of the motion fault detector.
package mfd_pkg;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_GOFS_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GOFS_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GOFS_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REST_Z = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FF_LIM = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_IMP_LIM = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SHK_HI = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SHK_MED = 3'd7;

	localparam logic [1:0] HEALTH_OK = 2'd0;
	localparam logic [1:0] HEALTH_WARN = 2'd1;
	localparam logic [1:0] HEALTH_CRIT = 2'd2;

	localparam logic [2:0] MOTION_STATIONARY = 3'd0;
	localparam logic [2:0] MOTION_UP = 3'd1;
	localparam logic [2:0] MOTION_DOWN = 3'd2;
	localparam logic [2:0] MOTION_FREE_FALL = 3'd3;
	localparam logic [2:0] MOTION_SHAKING = 3'd4;

	localparam logic [1:0] FAULT_CLEAN = 2'd0;
	localparam logic [1:0] FAULT_FREE_FALL = 2'd1;
	localparam logic [1:0] FAULT_IMPACT = 2'd2;
	localparam logic [1:0] FAULT_SHAKING = 2'd3;

	localparam int MOVE_BAND_Q = 819;
	localparam logic signed [19:0] SZ_RESET = 20'sd16384;

	// Configuration as seen by the front part.
	typedef struct packed {
		logic signed [15:0] gofs_x;
		logic signed [15:0] gofs_y;
		logic signed [15:0] gofs_z;
		logic signed [15:0] rest_z;
		logic [14:0] ff_lim;
		logic [14:0] imp_lim;
		logic [14:0] shk_hi;
		logic [14:0] shk_med;
	} cfg_t;

	// Classified word handed from the front part to the back part.
	typedef struct packed {
		logic [1:0] level;
		logic [1:0] fault;
		logic signed [15:0] measure;
		logic signed [15:0] az;
	} cls_t;

	localparam int CLS_W = $bits(cls_t);
endpackage

// ===== rtl/mfd_isqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
module mfd_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [33:0] radicand,
	output logic        busy,
	output logic        done,
	output logic [16:0] root
);
	logic [33:0] rem_q;
	logic [33:0] root_q;
	logic [33:0] bit_q;
	logic [33:0] trial;

	assign trial = root_q + bit_q;
	assign root = root_q[16:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start && !busy) begin
				busy <= 1'b1;
			end else if (busy) begin
				if (bit_q[1:0] != 2'b00 || bit_q == 34'd0) begin
					busy <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			rem_q <= radicand;
			root_q <= '0;
			bit_q <= 34'h1 << 32;
		end else if (busy) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
endmodule

// ===== rtl/mfd_front.sv =====
// Front part: gyro correction, magnitude, and fault classification.
module mfd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mfd_pkg::cfg_t        cfg,
	input  logic                 push,
	output logic                 full,
	input  logic signed [15:0]   accel_x,
	input  logic signed [15:0]   accel_y,
	input  logic signed [15:0]   accel_z,
	input  logic signed [15:0]   gyro_x,
	input  logic signed [15:0]   gyro_y,
	input  logic signed [15:0]   gyro_z,
	output logic                 cls_valid,
	output mfd_pkg::cls_t        cls,
	input  logic                 cls_ready
);
	import mfd_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_SQ, ST_ROOT, ST_SEND} state_t;
	state_t state_q;

	logic signed [15:0] az_q;
	logic signed [16:0] gx_d, gy_d, gz_d;
	logic [31:0] sqx_q, sqy_q, sqz_q;
	logic [17:0] gsum_q;
	logic [33:0] sq_sum;
	logic sq_start, sq_busy, sq_done;
	logic [16:0] mag;
	logic [15:0] ax_a, ay_a, az_a;
	logic signed [16:0] dz;
	logic [16:0] dz_abs;
	logic [17:0] hi2, med2;

	function automatic logic [15:0] abs_sat(input logic signed [16:0] v);
		logic signed [16:0] s;
		s = (v > 17'sd32767) ? 17'sd32767 : ((v < -17'sd32768) ? -17'sd32768 : v);
		return s[16] ? 16'(-s) : s[15:0];
	endfunction

	assign gx_d = 17'(gyro_x) - 17'(cfg.gofs_x);
	assign gy_d = 17'(gyro_y) - 17'(cfg.gofs_y);
	assign gz_d = 17'(gyro_z) - 17'(cfg.gofs_z);
	assign ax_a = accel_x[15] ? 16'(-accel_x) : accel_x;
	assign ay_a = accel_y[15] ? 16'(-accel_y) : accel_y;
	assign az_a = accel_z[15] ? 16'(-accel_z) : accel_z;
	assign sq_sum = 34'(sqx_q) + 34'(sqy_q) + 34'(sqz_q);
	assign sq_start = (state_q == ST_SQ);
	assign full = (state_q != ST_IDLE);
	assign dz = 17'(az_q) - 17'(cfg.rest_z);
	assign dz_abs = dz[16] ? 17'(-dz) : dz;
	assign hi2 = {2'b00, cfg.shk_hi, 1'b0};
	assign med2 = {2'b00, cfg.shk_med, 1'b0};

	mfd_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(sq_sum),
		.busy(sq_busy), .done(sq_done), .root(mag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cls_valid <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (push) state_q <= ST_SQ;
				ST_SQ: state_q <= ST_ROOT;
				ST_ROOT: begin
					if (sq_done) begin
						cls_valid <= 1'b1;
						state_q <= ST_SEND;
					end
				end
				ST_SEND: begin
					if (cls_ready) begin
						cls_valid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && push) begin
			az_q <= accel_z;
			gsum_q <= 18'(abs_sat(gx_d)) + 18'(abs_sat(gy_d)) + 18'(abs_sat(gz_d));
			sqx_q <= ax_a * ax_a;
			sqy_q <= ay_a * ay_a;
			sqz_q <= az_a * az_a;
		end
		if (state_q == ST_ROOT && sq_done) begin
			cls.az <= az_q;
			if (mag < 17'(cfg.ff_lim)) begin
				cls.level <= HEALTH_CRIT;
				cls.fault <= FAULT_FREE_FALL;
				cls.measure <= (mag > 17'd32767) ? 16'sd32767 : mag[15:0];
			end else if (dz_abs > 17'(cfg.imp_lim)) begin
				cls.level <= HEALTH_CRIT;
				cls.fault <= FAULT_IMPACT;
				cls.measure <= (dz > 17'sd32767) ? 16'sd32767 :
					((dz < -17'sd32768) ? -16'sd32768 : dz[15:0]);
			end else if (gsum_q > hi2) begin
				cls.level <= HEALTH_CRIT;
				cls.fault <= FAULT_SHAKING;
				cls.measure <= (gsum_q[17:1] > 17'd32767) ? 16'sd32767 : gsum_q[16:1];
			end else if (gsum_q > med2) begin
				cls.level <= HEALTH_WARN;
				cls.fault <= FAULT_SHAKING;
				cls.measure <= (gsum_q[17:1] > 17'd32767) ? 16'sd32767 : gsum_q[16:1];
			end else begin
				cls.level <= HEALTH_OK;
				cls.fault <= FAULT_CLEAN;
				cls.measure <= '0;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) sq_done |-> state_q == ST_ROOT)
		else $error("root finished outside its wait state");
	assert property (@(posedge clk) disable iff (!arst_n) sq_busy |-> state_q == ST_ROOT)
		else $error("root unit busy outside its wait state");
	assert property (@(posedge clk) disable iff (!arst_n) cls_valid |-> full)
		else $error("classified word shown while front is idle");
	assert property (@(posedge clk) disable iff (!arst_n) (cls_valid && !cls_ready) |=> $stable(cls))
		else $error("stalled classified word changed");
endmodule

// ===== rtl/mfd_fifo.sv =====
// Short queue between the front and the back part.
module mfd_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_valid,
	input  logic [W-1:0] wr_data,
	output logic         wr_ready,
	output logic         rd_valid,
	output logic [W-1:0] rd_data,
	input  logic         rd_ready
);
	logic [W-1:0] mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
endmodule

// ===== rtl/mfd_back.sv =====
// Back part: debounce, cooldown, smoothing and result register.
module mfd_back #(
	parameter int DEBOUNCE_SAMPLES = 10,
	parameter int COOLDOWN_SAMPLES = 300,
	parameter int SMOOTH_SHIFT = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [15:0] rest_z,
	input  logic               cls_valid,
	input  mfd_pkg::cls_t      cls,
	output logic               cls_ready,
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         health,
	output logic [2:0]         motion,
	output logic [1:0]         sample_fault,
	output logic               alarm_fire,
	output logic signed [15:0] alarm_value,
	output logic [2:0]         alarm_prior_motion
);
	import mfd_pkg::*;

	logic [3:0] deb_q;
	logic [1:0] health_q;
	logic [2:0] motion_q;
	logic [8:0] cool_q;
	logic signed [19:0] sz_q;

	logic take;
	logic [8:0] cool_inc;
	logic [3:0] deb_n;
	logic [1:0] health_n;
	logic [2:0] motion_n;
	logic [8:0] cool_n;
	logic fire;
	logic signed [22:0] delta, step, nz;
	logic signed [19:0] sz_n;
	logic signed [20:0] lin;

	assign take = cls_valid && (empty || pop);
	assign cls_ready = empty || pop;

	always_comb begin
		cool_inc = (cool_q < 9'(COOLDOWN_SAMPLES)) ? cool_q + 9'd1 : cool_q;
		deb_n = deb_q;
		health_n = health_q;
		cool_n = cool_inc;
		fire = 1'b0;
		if (cls.level != HEALTH_OK) begin
			if (deb_q < 4'(DEBOUNCE_SAMPLES)) begin
				deb_n = deb_q + 4'd1;
			end else if (health_q != cls.level) begin
				if (cls.level == HEALTH_CRIT && cool_inc >= 9'(COOLDOWN_SAMPLES)) begin
					fire = 1'b1;
					cool_n = '0;
				end
				health_n = cls.level;
			end
		end else begin
			if (deb_q != 4'd0) deb_n = deb_q - 4'd1;
			else health_n = HEALTH_OK;
		end
		delta = (23'(cls.az) <<< 2) - 23'(sz_q);
		step = (delta + 23'(1 << (SMOOTH_SHIFT - 1))) >>> SMOOTH_SHIFT;
		nz = 23'(sz_q) + step;
		sz_n = (nz > 23'sd524287) ? 20'sd524287 :
			((nz < -23'sd524288) ? -20'sd524288 : nz[19:0]);
		lin = 21'(sz_n) - (21'(rest_z) <<< 2);
		motion_n = motion_q;
		if (health_n == HEALTH_OK) begin
			if (lin > 21'sd819) motion_n = MOTION_UP;
			else if (lin < -21'sd819) motion_n = MOTION_DOWN;
			else motion_n = MOTION_STATIONARY;
		end else if (health_n == HEALTH_CRIT) begin
			motion_n = (cls.fault == FAULT_FREE_FALL) ? MOTION_FREE_FALL : MOTION_SHAKING;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_q <= '0;
			health_q <= HEALTH_OK;
			motion_q <= MOTION_STATIONARY;
			cool_q <= 9'(COOLDOWN_SAMPLES);
			sz_q <= SZ_RESET;
			empty <= 1'b1;
		end else begin
			if (take) begin
				deb_q <= deb_n;
				health_q <= health_n;
				motion_q <= motion_n;
				cool_q <= cool_n;
				sz_q <= sz_n;
				empty <= 1'b0;
			end else if (pop) begin
				empty <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			health <= health_n;
			motion <= motion_n;
			sample_fault <= cls.fault;
			alarm_fire <= fire;
			alarm_value <= fire ? cls.measure : '0;
			alarm_prior_motion <= fire ? motion_q : MOTION_STATIONARY;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) deb_q <= 4'(DEBOUNCE_SAMPLES))
		else $error("debounce count past its limit");
	assert property (@(posedge clk) disable iff (!arst_n) cool_q <= 9'(COOLDOWN_SAMPLES))
		else $error("cooldown count past its limit");
	assert property (@(posedge clk) disable iff (!arst_n) (take && fire) |=> cool_q == 9'd0)
		else $error("cooldown not restarted after alarm");
endmodule

// ===== rtl/motion_fault_detector.sv =====
// Top level of the motion fault detector.
//  channel  | handshake     | ports
//  sample   | push / full   | accel_x..z, gyro_x..z
//  result   | pop / empty   | health, motion, sample_fault, alarm_*
//  config   | cfg_we        | cfg_index, cfg_data
// The front takes a new sample only once the previous word has left it: it squares
// the axes, runs the square root unit that resolves two radicand bits per cycle,
// classifies the sample and hands the word to the queue, waiting while it is full.
// A two-word queue lets the front classify the next word while the back stalls.
// Reset is asynchronous; it clears control and config registers, not data ones.
// full stays high from acceptance until the classified word leaves the front.
module motion_fault_detector #(
	parameter int DEBOUNCE_SAMPLES = 10,
	parameter int COOLDOWN_SAMPLES = 300,
	parameter int SMOOTH_SHIFT = 2
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mfd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mfd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             push,
	output logic                             full,
	input  logic signed [15:0]               accel_x,
	input  logic signed [15:0]               accel_y,
	input  logic signed [15:0]               accel_z,
	input  logic signed [15:0]               gyro_x,
	input  logic signed [15:0]               gyro_y,
	input  logic signed [15:0]               gyro_z,
	output logic                             empty,
	input  logic                             pop,
	output logic [1:0]                       health,
	output logic [2:0]                       motion,
	output logic [1:0]                       sample_fault,
	output logic                             alarm_fire,
	output logic signed [15:0]               alarm_value,
	output logic [2:0]                       alarm_prior_motion
);
	import mfd_pkg::*;

	cfg_t cfg_q;
	logic f_valid, f_ready, q_valid, q_ready;
	cls_t f_cls, q_cls;
	logic [CLS_W-1:0] q_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gofs_x <= '0;
			cfg_q.gofs_y <= '0;
			cfg_q.gofs_z <= '0;
			cfg_q.rest_z <= 16'sd4096;
			cfg_q.ff_lim <= 15'd1433;
			cfg_q.imp_lim <= 15'd1228;
			cfg_q.shk_hi <= 15'd492;
			cfg_q.shk_med <= 15'd229;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GOFS_X: cfg_q.gofs_x <= cfg_data;
				REG_GOFS_Y: cfg_q.gofs_y <= cfg_data;
				REG_GOFS_Z: cfg_q.gofs_z <= cfg_data;
				REG_REST_Z: cfg_q.rest_z <= cfg_data;
				REG_FF_LIM: cfg_q.ff_lim <= cfg_data[14:0];
				REG_IMP_LIM: cfg_q.imp_lim <= cfg_data[14:0];
				REG_SHK_HI: cfg_q.shk_hi <= cfg_data[14:0];
				REG_SHK_MED: cfg_q.shk_med <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	mfd_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .push(push), .full(full),
		.accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
		.gyro_x(gyro_x), .gyro_y(gyro_y), .gyro_z(gyro_z),
		.cls_valid(f_valid), .cls(f_cls), .cls_ready(f_ready)
	);

	mfd_fifo #(.W(CLS_W)) u_fifo (
		.clk(clk), .arst_n(arst_n), .wr_valid(f_valid), .wr_data(f_cls),
		.wr_ready(f_ready), .rd_valid(q_valid), .rd_data(q_raw), .rd_ready(q_ready)
	);

	assign q_cls = cls_t'(q_raw);

	mfd_back #(
		.DEBOUNCE_SAMPLES(DEBOUNCE_SAMPLES),
		.COOLDOWN_SAMPLES(COOLDOWN_SAMPLES),
		.SMOOTH_SHIFT(SMOOTH_SHIFT)
	) u_back (
		.clk(clk), .arst_n(arst_n), .rest_z(cfg_q.rest_z),
		.cls_valid(q_valid), .cls(q_cls), .cls_ready(q_ready),
		.empty(empty), .pop(pop), .health(health), .motion(motion),
		.sample_fault(sample_fault), .alarm_fire(alarm_fire),
		.alarm_value(alarm_value), .alarm_prior_motion(alarm_prior_motion)
	);
endmodule

// ===== tb/motion_fault_detector_tb.sv =====
// Self-checking testbench of the motion fault detector with a scoreboard class.
module motion_fault_detector_tb;
	import mfd_pkg::*;

	localparam int DEBOUNCE = 10;
	localparam int COOLDOWN = 300;
	localparam int SHIFT = 2;

	typedef struct {
		logic [1:0] health;
		logic [2:0] motion;
		logic [1:0] fault;
		logic fire;
		logic signed [15:0] value;
		logic [2:0] prior;
	} verdict_t;

	typedef struct {
		logic signed [15:0] ax, ay, az, gx, gy, gz;
	} sample_t;

	class fault_scoreboard;
		int errors;
		verdict_t verdicts[$];
		cfg_t cfg;
		int unsigned debounce_cnt, cooldown_cnt;
		logic [1:0] health_now;
		logic [2:0] motion_now;
		int smooth_z;

		function new();
			errors = 0;
			cfg.gofs_x = '0;
			cfg.gofs_y = '0;
			cfg.gofs_z = '0;
			cfg.rest_z = 16'sd4096;
			cfg.ff_lim = 15'd1433;
			cfg.imp_lim = 15'd1228;
			cfg.shk_hi = 15'd492;
			cfg.shk_med = 15'd229;
			debounce_cnt = 0;
			cooldown_cnt = COOLDOWN;
			health_now = HEALTH_OK;
			motion_now = MOTION_STATIONARY;
			smooth_z = 16384;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
			case (idx)
				REG_GOFS_X: cfg.gofs_x = data;
				REG_GOFS_Y: cfg.gofs_y = data;
				REG_GOFS_Z: cfg.gofs_z = data;
				REG_REST_Z: cfg.rest_z = data;
				REG_FF_LIM: cfg.ff_lim = data[14:0];
				REG_IMP_LIM: cfg.imp_lim = data[14:0];
				REG_SHK_HI: cfg.shk_hi = data[14:0];
				default: cfg.shk_med = data[14:0];
			endcase
		endfunction

		function int clip16(longint v);
			if (v > 32767) return 32767;
			if (v < -32768) return -32768;
			return int'(v);
		endfunction

		// Floor square root, one result bit per iteration.
		function int unsigned root_of(longint unsigned n);
			longint unsigned r;
			longint unsigned t;
			r = 0;
			for (int b = 16; b >= 0; b--) begin
				t = r | (64'd1 << b);
				if (t * t <= n) r = t;
			end
			return int'(r);
		endfunction

		function void note_sample(sample_t s);
			int gx, gy, gz, gsum, dz, adz, measure, delta, stepv, lin;
			longint unsigned sq;
			int unsigned mag;
			logic [1:0] level, fault;
			verdict_t v;
			gx = clip16(int'(s.gx) - int'(cfg.gofs_x));
			gy = clip16(int'(s.gy) - int'(cfg.gofs_y));
			gz = clip16(int'(s.gz) - int'(cfg.gofs_z));
			gsum = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy) + (gz < 0 ? -gz : gz);
			sq = longint'(s.ax) * s.ax + longint'(s.ay) * s.ay + longint'(s.az) * s.az;
			mag = root_of(sq);
			dz = int'(s.az) - int'(cfg.rest_z);
			adz = dz < 0 ? -dz : dz;
			level = HEALTH_OK;
			fault = FAULT_CLEAN;
			measure = 0;
			v.prior = motion_now;
			v.fire = 1'b0;
			v.value = '0;
			if (mag < cfg.ff_lim) begin
				level = HEALTH_CRIT; fault = FAULT_FREE_FALL; measure = clip16(mag);
			end else if (adz > int'(cfg.imp_lim)) begin
				level = HEALTH_CRIT; fault = FAULT_IMPACT; measure = clip16(dz);
			end else if (gsum > 2 * int'(cfg.shk_hi)) begin
				level = HEALTH_CRIT; fault = FAULT_SHAKING; measure = clip16(gsum / 2);
			end else if (gsum > 2 * int'(cfg.shk_med)) begin
				level = HEALTH_WARN; fault = FAULT_SHAKING; measure = clip16(gsum / 2);
			end
			if (cooldown_cnt < COOLDOWN) cooldown_cnt++;
			if (level != HEALTH_OK) begin
				if (debounce_cnt < DEBOUNCE) begin
					debounce_cnt++;
				end else if (health_now != level) begin
					if (level == HEALTH_CRIT && cooldown_cnt >= COOLDOWN) begin
						v.fire = 1'b1;
						v.value = 16'(measure);
						cooldown_cnt = 0;
					end
					health_now = level;
				end
			end else begin
				if (debounce_cnt > 0) debounce_cnt--;
				else health_now = HEALTH_OK;
			end
			// Round half up, then clamp to the 20-bit accumulator.
			delta = int'(s.az) * 4 - smooth_z;
			stepv = (delta + (1 << (SHIFT - 1))) >>> SHIFT;
			smooth_z = smooth_z + stepv;
			if (smooth_z > 524287) smooth_z = 524287;
			if (smooth_z < -524288) smooth_z = -524288;
			lin = smooth_z - int'(cfg.rest_z) * 4;
			if (health_now == HEALTH_OK) begin
				if (lin > MOVE_BAND_Q) motion_now = MOTION_UP;
				else if (lin < -MOVE_BAND_Q) motion_now = MOTION_DOWN;
				else motion_now = MOTION_STATIONARY;
			end else if (health_now == HEALTH_CRIT) begin
				motion_now = (fault == FAULT_FREE_FALL) ? MOTION_FREE_FALL : MOTION_SHAKING;
			end
			v.health = health_now;
			v.motion = motion_now;
			v.fault = fault;
			if (!v.fire) v.prior = MOTION_STATIONARY;
			verdicts.push_back(v);
		endfunction

		function void check_result(verdict_t got);
			verdict_t e;
			if (verdicts.size() == 0) begin
				$display("%0t: unexpected word, actual health %0d", $time, got.health);
				errors++;
				return;
			end
			e = verdicts.pop_front();
			if (got.health !== e.health) begin
				$display("%0t: health expected %0d actual %0d", $time, e.health, got.health);
				errors++;
			end
			if (got.motion !== e.motion) begin
				$display("%0t: motion expected %0d actual %0d", $time, e.motion, got.motion);
				errors++;
			end
			if (got.fault !== e.fault) begin
				$display("%0t: fault expected %0d actual %0d", $time, e.fault, got.fault);
				errors++;
			end
			if (got.fire !== e.fire) begin
				$display("%0t: alarm expected %0d actual %0d", $time, e.fire, got.fire);
				errors++;
			end
			if (got.value !== e.value) begin
				$display("%0t: alarm value expected %0d actual %0d", $time, e.value, got.value);
				errors++;
			end
			if (got.prior !== e.prior) begin
				$display("%0t: prior motion expected %0d actual %0d", $time, e.prior, got.prior);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, cfg_we, push, pop, full, empty;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic signed [15:0] accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z;
	logic [1:0] health, sample_fault;
	logic [2:0] motion, alarm_prior_motion;
	logic alarm_fire;
	logic signed [15:0] alarm_value;

	fault_scoreboard sb = new();
	bit idle_on = 1;
	bit hold_req = 0;

	motion_fault_detector dut (.*);

	always begin
		clk = 1; #5;
		clk = 0; #5;
	end

	initial begin
		#50_000_000;
		$display("status: fail");
		$finish;
	end

	// Result side: checks each popped word, stalls at random while idle_on is set, and holds pop low on a hold request.
	initial begin
		int stall;
		verdict_t got;
		stall = 0;
		pop <= 0;
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				got.health = health;
				got.motion = motion;
				got.fault = sample_fault;
				got.fire = alarm_fire;
				got.value = alarm_value;
				got.prior = alarm_prior_motion;
				sb.check_result(got);
			end
			if (hold_req) begin
				hold_req = 0;
				stall = 300;
			end
			if (stall > 0) begin
				stall--;
				pop <= 0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(0, 10);
				pop <= 0;
			end else begin
				pop <= 1;
			end
		end
	end

	// Consecutive writes keep the enable high; load_cfg drops it after the last one.
	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.write_reg(idx, data);
		@(posedge clk);
	endtask

	task automatic wait_drained();
		push <= 0;
		while (sb.verdicts.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic send_sample(sample_t s);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			push <= 0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		push <= 1;
		accel_x <= s.ax;
		accel_y <= s.ay;
		accel_z <= s.az;
		gyro_x <= s.gx;
		gyro_y <= s.gy;
		gyro_z <= s.gz;
		do @(posedge clk); while (full);
		sb.note_sample(s);
	endtask

	function automatic logic signed [15:0] near(int center, int spread);
		return 16'(sb.clip16(longint'(center) + $signed($urandom_range(0, 2 * spread)) - spread));
	endfunction

	// Builds one sample of a given class around the current calibration; the random class ignores it.
	function automatic sample_t make_sample(int kind);
		sample_t s;
		int mag;
		s.ax = near(0, 300);
		s.ay = near(0, 300);
		s.az = near(sb.cfg.rest_z, 200);
		s.gx = near(sb.cfg.gofs_x, 100);
		s.gy = near(sb.cfg.gofs_y, 100);
		s.gz = near(sb.cfg.gofs_z, 100);
		case (kind)
			1: begin
				s.ax = near(0, 500); s.ay = near(0, 500); s.az = near(0, 500);
			end
			2: begin
				mag = int'(sb.cfg.imp_lim) + $urandom_range(1, 3000);
				s.az = 16'(sb.clip16(sb.cfg.rest_z + ($urandom_range(0, 1) ? mag : -mag)));
			end
			3: begin
				s.gx = near(sb.cfg.gofs_x, 900);
				s.gy = near(sb.cfg.gofs_y, 900);
				s.gz = near(sb.cfg.gofs_z, 900);
			end
			4: begin
				s = '{16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 16'($urandom)};
			end
			default: ;
		endcase
		return s;
	endfunction

	task automatic run_bursts(int count);
		int kind, run;
		while (count > 0) begin
			kind = $urandom_range(0, 9);
			kind = kind < 4 ? 0 : kind < 9 ? kind - 3 : 4;
			if (kind > 4) kind = 0;
			run = $urandom_range(1, 25);
			for (int i = 0; i < run && count > 0; i++) begin
				send_sample(make_sample(kind));
				count--;
			end
		end
	endtask

	task automatic load_cfg(int gx, int gy, int gz, int rz, int ff, int imp, int hi, int med);
		write_cfg(REG_GOFS_X, 16'(gx));
		write_cfg(REG_GOFS_Y, 16'(gy));
		write_cfg(REG_GOFS_Z, 16'(gz));
		write_cfg(REG_REST_Z, 16'(rz));
		write_cfg(REG_FF_LIM, 16'(ff));
		write_cfg(REG_IMP_LIM, 16'(imp));
		write_cfg(REG_SHK_HI, 16'(hi));
		write_cfg(REG_SHK_MED, 16'(med));
		cfg_we <= 0;
	endtask

	initial begin
		arst_n = 0;
		cfg_we <= 0;
		cfg_index <= REG_GOFS_X;
		cfg_data <= 0;
		push <= 0;
		{accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z} <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed samples under the reset calibration.
		send_sample('{0, 0, 0, 0, 0, 0});
		send_sample('{-32768, -32768, -32768, -32768, -32768, -32768});
		send_sample('{32767, 32767, 32767, 32767, 32767, 32767});
		send_sample('{0, 0, 4096, 600, 600, 0});
		send_sample('{0, 0, 4096, 300, 200, 0});
		send_sample('{0, 0, 6000, 0, 0, 0});
		send_sample('{0, 0, 2000, 0, 0, 0});
		for (int i = 0; i < 14; i++) send_sample('{0, 0, 4096, 0, 0, 700});
		run_bursts(500);
		hold_req = 1;
		run_bursts(40);
		wait_drained();

		// Offsets at the extremes so the corrected rates saturate; limits at full scale.
		load_cfg(32767, -32768, 32767, -32768, 32767, 32767, 32767, 32767);
		send_sample('{0, 0, 0, -32768, 32767, -32768});
		run_bursts(150);
		wait_drained();

		// All limits at zero: nearly every sample is a fault.
		load_cfg(-32768, 32767, -32768, 32767, 0, 0, 0, 0);
		run_bursts(200);
		wait_drained();

		load_cfg($urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200,
			$urandom_range(0, 400) - 200, $urandom_range(3000, 5000),
			$urandom_range(500, 2000), $urandom_range(500, 2000),
			$urandom_range(300, 600), $urandom_range(100, 300));
		run_bursts(300);
		wait_drained();

		load_cfg(0, 0, 0, 4096, 1433, 1228, 492, 229);
		run_bursts(300);
		idle_on = 0;
		run_bursts(250);
		push <= 0;
		while (sb.verdicts.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
